FILE: hdl/bmsc_pkg.sv
package bmsc_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 10;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TICKS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_INITIAL     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FIRST       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_SECOND      = 3'd4;

	// Field widths
	localparam int DEB_W = 8;
	localparam int LONG_W = 10;
	localparam int DUTY_W = 8;
	localparam int STEP_W = 3;
	localparam int COLOUR_W = 3;

	// Register reset values
	localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 8'd2;
	localparam logic [LONG_W-1:0] LONG_PRESS_RST = 10'd400;
	localparam logic [DUTY_W-1:0] DUTY_INITIAL_RST = 8'd21;
	localparam logic [DUTY_W-1:0] DUTY_FIRST_RST = 8'd34;
	localparam logic [DUTY_W-1:0] DUTY_SECOND_RST = 8'd77;

	// Divider stages after the base slot: 10ms -> 50ms -> 100ms -> 200ms
	localparam logic [2:0] TEN_MS_LAST = 3'd4;

	// Motor step codes
	localparam logic [STEP_W-1:0] STEP_FIRST   = 3'd2;
	localparam logic [STEP_W-1:0] STEP_SECOND  = 3'd3;
	localparam logic [STEP_W-1:0] STEP_PULSE   = 3'd4;

	// Per-button sample result for the current request
	typedef struct packed {
		logic held;       // debounced press state after this request
		logic press;      // fresh short press seen on this 10ms event
		logic long_stop;  // held with long press flag: stop the motor
	} btn_evt_t;

endpackage

FILE: hdl/bmsc_button.sv
module bmsc_button
	import bmsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample,
	input  logic              level,
	input  logic [DEB_W-1:0]  debounce_ticks,
	input  logic [LONG_W-1:0] long_press_ticks,
	output btn_evt_t          evt
);

	logic [DEB_W-1:0]  debounce_q, debounce_d;
	logic [LONG_W-1:0] long_q, long_d;
	logic              long_seen_q, long_seen_d;
	logic              handled_q, handled_d;
	logic              held_d;

	// Debounce and long press countdowns, press edge detect
	always_comb begin
		if (!level) begin
			debounce_d = (debounce_q != '0) ? debounce_q - 1'b1 : '0;
			long_d = (long_q != '0) ? long_q - 1'b1 : '0;
			long_seen_d = (long_d == '0) ? 1'b1 : long_seen_q;
		end else begin
			debounce_d = debounce_ticks;
			long_d = long_press_ticks;
			long_seen_d = 1'b0;
		end
		held_d = (debounce_d == '0);
		if (held_d) begin
			handled_d = long_seen_d ? handled_q : 1'b1;
		end else begin
			handled_d = 1'b0;
		end
		evt.held = sample ? held_d : (debounce_q == '0);
		evt.press = sample && held_d && !long_seen_d && !handled_q;
		evt.long_stop = sample && held_d && long_seen_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			long_q <= LONG_PRESS_RST;
			long_seen_q <= 1'b0;
			handled_q <= 1'b0;
		end else if (sample) begin
			debounce_q <= debounce_d;
			long_q <= long_d;
			long_seen_q <= long_seen_d;
			handled_q <= handled_d;
		end
	end

endmodule

FILE: hdl/button_motor_speed_controller_top.sv
// Button motor speed controller.
// Each request on the input channel (in_valid/in_ready) is one base timer tick
// with the raw active-low levels of the motor button and the colour button.
// Every tick yields exactly one result on the output channel
// (out_valid/out_ready): duty compare, PWM enable, driver sleep pin, motor
// step, pulsating flag, colour index and both debounced button states, all
// as they stand after that tick.
// A cascaded divider turns BASE_TICKS_PER_SLOT ticks into a 10ms event and
// further into a 200ms event; buttons are sampled on 10ms events only.
// A request passes the input register, then the state update into the result
// register, where out_valid rises.
// One request per cycle is sustained while out_ready stays high;
// the only loop is the state update between the two registers.
// When the receiver stalls, the result register holds and the input register
// still takes one more request; in_ready drops once both are full.
// Reset (arst_n low) clears the divider and motor state, reloads the button
// countdowns and returns all registers on the cfg port to their defaults.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at once
// for the next reload; an index beyond the register list is ignored.
module button_motor_speed_controller_top
	import bmsc_pkg::*;
#(
	parameter int BASE_TICKS_PER_SLOT = 10,
	parameter int COLOUR_COUNT = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  button_one_level,
	input  logic                  button_two_level,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DUTY_W-1:0]     duty_compare,
	output logic                  pwm_enabled,
	output logic                  sleep_pin_level,
	output logic [STEP_W-1:0]     motor_step,
	output logic                  pulsating,
	output logic [COLOUR_W-1:0]   colour_index,
	output logic                  button_one_held,
	output logic                  button_two_held
);

	localparam int BASE_W = (BASE_TICKS_PER_SLOT > 1) ? $clog2(BASE_TICKS_PER_SLOT) : 1;
	localparam int CNT_W = (COLOUR_COUNT > 2) ? $clog2(COLOUR_COUNT) : 1;
	localparam int CEXT_W = (CNT_W > COLOUR_W) ? CNT_W : COLOUR_W;
	localparam logic [BASE_W-1:0] BASE_LAST = BASE_W'(BASE_TICKS_PER_SLOT - 1);
	localparam logic [CNT_W-1:0] COLOUR_LAST = CNT_W'(COLOUR_COUNT - 1);

	// Configuration registers
	logic [DEB_W-1:0]  debounce_ticks_q;
	logic [LONG_W-1:0] long_press_ticks_q;
	logic [DUTY_W-1:0] duty_initial_q, duty_first_q, duty_second_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q <= DEBOUNCE_RST;
			long_press_ticks_q <= LONG_PRESS_RST;
			duty_initial_q <= DUTY_INITIAL_RST;
			duty_first_q <= DUTY_FIRST_RST;
			duty_second_q <= DUTY_SECOND_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_DEBOUNCE_TICKS:   debounce_ticks_q <= cfg_data[DEB_W-1:0];
				CFG_LONG_PRESS_TICKS: long_press_ticks_q <= cfg_data[LONG_W-1:0];
				CFG_DUTY_INITIAL:     duty_initial_q <= cfg_data[DUTY_W-1:0];
				CFG_DUTY_FIRST:       duty_first_q <= cfg_data[DUTY_W-1:0];
				CFG_DUTY_SECOND:      duty_second_q <= cfg_data[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	logic valid_s1, b1_level_s1, b2_level_s1;
	logic advance;

	assign advance = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			b1_level_s1 <= button_one_level;
			b2_level_s1 <= button_two_level;
		end
	end

	// Cascaded divider
	logic [BASE_W-1:0] base_q, base_d;
	logic [2:0]        ten_q, ten_d;
	logic              fifty_q, fifty_d, hundred_q, hundred_d;
	logic              ev10, ev200;

	always_comb begin
		base_d = base_q;
		ten_d = ten_q;
		fifty_d = fifty_q;
		hundred_d = hundred_q;
		ev10 = 1'b0;
		ev200 = 1'b0;
		if (base_q == BASE_LAST) begin
			base_d = '0;
			ev10 = 1'b1;
			if (ten_q == TEN_MS_LAST) begin
				ten_d = '0;
				if (fifty_q) begin
					fifty_d = 1'b0;
					if (hundred_q) begin
						hundred_d = 1'b0;
						ev200 = 1'b1;
					end else begin
						hundred_d = 1'b1;
					end
				end else begin
					fifty_d = 1'b1;
				end
			end else begin
				ten_d = ten_q + 1'b1;
			end
		end else begin
			base_d = base_q + 1'b1;
		end
	end

	// Button channels
	btn_evt_t b1_evt, b2_evt;

	bmsc_button u_button_one (
		.clk              (clk),
		.arst_n           (arst_n),
		.sample           (advance && ev10),
		.level            (b1_level_s1),
		.debounce_ticks   (debounce_ticks_q),
		.long_press_ticks (long_press_ticks_q),
		.evt              (b1_evt)
	);

	bmsc_button u_button_two (
		.clk              (clk),
		.arst_n           (arst_n),
		.sample           (advance && ev10),
		.level            (b2_level_s1),
		.debounce_ticks   (debounce_ticks_q),
		.long_press_ticks (long_press_ticks_q),
		.evt              (b2_evt)
	);

	// Motor and colour state
	logic [STEP_W-1:0] step_q, step_d;
	logic [DUTY_W-1:0] duty_q, duty_d;
	logic [CNT_W-1:0]  colour_q, colour_d;
	logic              running_q, running_d, pulse_q, pulse_d;
	logic              phase_q, phase_d, sleep_q, sleep_d;
	logic [CEXT_W-1:0] colour_ext;

	always_comb begin
		step_d = step_q;
		duty_d = duty_q;
		running_d = running_q;
		pulse_d = pulse_q;
		phase_d = phase_q;
		sleep_d = sleep_q;
		colour_d = colour_q;

		// motor button: long press stops, fresh press steps
		if (b1_evt.long_stop) begin
			pulse_d = 1'b0;
			step_d = '0;
			duty_d = duty_initial_q;
			running_d = 1'b0;
			sleep_d = 1'b0;
		end else if (b1_evt.press) begin
			step_d = step_q + 1'b1;
			if (!running_q) begin
				running_d = 1'b1;
				sleep_d = 1'b1;
			end else if (step_d == STEP_FIRST) begin
				duty_d = duty_first_q;
			end else if (step_d == STEP_SECOND) begin
				duty_d = duty_second_q;
			end else if (step_d == STEP_PULSE) begin
				pulse_d = 1'b1;
				duty_d = duty_second_q;
			end else if (step_d > STEP_PULSE) begin
				pulse_d = 1'b0;
				step_d = '0;
				duty_d = duty_initial_q;
				running_d = 1'b0;
				sleep_d = 1'b0;
			end
		end

		// colour button: long press stops the motor, fresh press steps colour
		if (b2_evt.long_stop) begin
			pulse_d = 1'b0;
			step_d = '0;
			duty_d = duty_initial_q;
			running_d = 1'b0;
			sleep_d = 1'b0;
		end else if (b2_evt.press) begin
			colour_d = (colour_q == COLOUR_LAST) ? '0 : colour_q + 1'b1;
		end

		// 200ms pulse toggle
		if (ev200 && pulse_d) begin
			phase_d = !phase_q;
			sleep_d = !phase_q;
		end
	end

	assign colour_ext = CEXT_W'(colour_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			ten_q <= '0;
			fifty_q <= 1'b0;
			hundred_q <= 1'b0;
			step_q <= '0;
			duty_q <= DUTY_INITIAL_RST;
			running_q <= 1'b0;
			pulse_q <= 1'b0;
			phase_q <= 1'b0;
			sleep_q <= 1'b0;
			colour_q <= '0;
		end else if (advance) begin
			base_q <= base_d;
			ten_q <= ten_d;
			fifty_q <= fifty_d;
			hundred_q <= hundred_d;
			step_q <= step_d;
			duty_q <= duty_d;
			running_q <= running_d;
			pulse_q <= pulse_d;
			phase_q <= phase_d;
			sleep_q <= sleep_d;
			colour_q <= colour_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			duty_compare <= duty_d;
			pwm_enabled <= running_d;
			sleep_pin_level <= sleep_d;
			motor_step <= step_d;
			pulsating <= pulse_d;
			colour_index <= colour_ext[COLOUR_W-1:0];
			button_one_held <= b1_evt.held;
			button_two_held <= b2_evt.held;
		end
	end

endmodule
